[rtl/ffbc_pkg.sv]
// Shared types, widths and codes for the flow forward/backward check unit.
// No dependencies; used by every module of the unit.
package ffbc_pkg;

	localparam int SEED_IDX_W    = 12;
	localparam int POS_W         = 12;
	localparam int FLOW_W        = 16;
	localparam int CAUSE_W       = 3;
	localparam int GRID_W        = 8;
	localparam int DIM_W         = 13;
	localparam int TGT_W         = 14;
	localparam int DIV_W         = 13;
	localparam int SQ_W          = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int Q_DEPTH       = 4;
	localparam int MAX_SEEDS_DEF = 4096;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_FWD_BIG  = 3'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_OFF_GRID = 3'd2;
	localparam logic [CAUSE_W-1:0] CAUSE_BWD_BIG  = 3'd3;
	localparam logic [CAUSE_W-1:0] CAUSE_MISMATCH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_GRID    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPC     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAXDISP = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd7;

	typedef struct packed {
		logic [GRID_W-1:0] grid;
		logic [GRID_W-2:0] off;
		logic [DIM_W-1:0]  spr;
		logic [DIM_W-1:0]  spc;
		logic [DIM_W-1:0]  iw;
		logic [DIM_W-1:0]  ih;
		logic [GRID_W-1:0] bw;
		logic [SQ_W-1:0]   md2;
		logic [SQ_W-1:0]   th2;
	} cfg_t;

	typedef struct packed {
		logic                     cmd;
		logic [SEED_IDX_W-1:0]    load_index;
		logic signed [FLOW_W-1:0] u;
		logic signed [FLOW_W-1:0] v;
		logic                     fwd_bad;
		logic                     negx;
		logic                     negy;
	} front_item_t;

	typedef struct packed {
		logic                     cmd;
		logic [SEED_IDX_W-1:0]    load_index;
		logic signed [FLOW_W-1:0] u;
		logic signed [FLOW_W-1:0] v;
		logic                     fwd_bad;
		logic signed [TGT_W-1:0]  sx;
		logic signed [TGT_W-1:0]  sy;
	} q_item_t;

endpackage

[rtl/ffbc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ffbc_pkg for widths.
module ffbc_div (
	input  logic                               clk,
	input  logic [ffbc_pkg::DIV_W-1:0]         num,
	input  logic [ffbc_pkg::GRID_W-1:0]        den,
	output logic [ffbc_pkg::DIV_W-1:0]         quo
);

	localparam int DW = ffbc_pkg::DIV_W;
	localparam int GW = ffbc_pkg::GRID_W;

	logic [DW-1:0] num_q [DW];
	logic [DW-1:0] quo_q [DW];
	logic [GW-1:0] rem_q [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [GW-1:0] rem_in;
		logic [DW-1:0] num_in;
		logic [DW-1:0] quo_in;
		logic [GW:0]   trial;
		logic [GW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign num_in = num_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign trial = {rem_in, num_in[DW-1-k]};
		assign diff  = trial - {1'b0, den};

		always_ff @(posedge clk) begin
			num_q[k] <= num_in;
			if (trial >= {1'b0, den}) begin
				rem_q[k] <= diff[GW-1:0];
				quo_q[k] <= quo_in | (DW'(1) << (DW-1-k));
			end else begin
				rem_q[k] <= trial[GW-1:0];
				quo_q[k] <= quo_in;
			end
		end
	end

	assign quo = quo_q[DW-1];

endmodule

[rtl/ffbc_front.sv]
// Front end: accepts beats, tests forward magnitude, rounds targets, finds seed.
// Depends on ffbc_pkg and ffbc_div.
module ffbc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ffbc_pkg::cfg_t                        cfg,
	input  logic                                  in_valid,
	input  logic                                  cmd,
	input  logic [ffbc_pkg::SEED_IDX_W-1:0]       load_index,
	input  logic [ffbc_pkg::POS_W-1:0]            seed_x,
	input  logic [ffbc_pkg::POS_W-1:0]            seed_y,
	input  logic signed [ffbc_pkg::FLOW_W-1:0]    flow_u,
	input  logic signed [ffbc_pkg::FLOW_W-1:0]    flow_v,
	output logic                                  push,
	output ffbc_pkg::q_item_t                     push_item
);

	localparam int DW = ffbc_pkg::DIV_W;
	localparam int TW = ffbc_pkg::TGT_W;

	function automatic logic signed [ffbc_pkg::TGT_W-1:0] round_tgt(
		input logic [ffbc_pkg::POS_W-1:0]         pos,
		input logic signed [ffbc_pkg::FLOW_W-1:0] f
	);
		logic signed [17:0]                 s;
		logic signed [ffbc_pkg::TGT_W-1:0]  q;
		logic [3:0]                         r;
		s = $signed({2'b00, pos, 4'b0000}) + 18'(f);
		q = ffbc_pkg::TGT_W'(s >>> 4);
		r = s[3:0];
		if (r > 4'd8 || (r == 4'd8 && q[0])) begin
			q = q + 1'b1;
		end
		return q;
	endfunction

	logic                              valid_s1;
	logic                              cmd_s1;
	logic [ffbc_pkg::SEED_IDX_W-1:0]   sidx_s1;
	logic [ffbc_pkg::POS_W-1:0]        x_s1, y_s1;
	logic signed [ffbc_pkg::FLOW_W-1:0] u_s1, v_s1;

	logic                              valid_s2;
	logic                              cmd_s2;
	logic [ffbc_pkg::SEED_IDX_W-1:0]   sidx_s2;
	logic signed [ffbc_pkg::FLOW_W-1:0] u_s2, v_s2;
	logic [ffbc_pkg::SQ_W-1:0]         fsq_s2;
	logic signed [TW-1:0]              x2_s2, y2_s2;

	logic                              valid_s3;
	ffbc_pkg::front_item_t             item_s3;
	logic [DW-1:0]                     magx_s3, magy_s3;

	logic signed [2*ffbc_pkg::FLOW_W-1:0] usq, vsq;
	logic signed [TW:0]                nx, ny, offs;
	logic signed [TW:0]                ax, ay;

	logic                              valid_d [DW];
	ffbc_pkg::front_item_t             item_d  [DW];
	logic [DW-1:0]                     qx, qy;

	assign usq = u_s1 * u_s1;
	assign vsq = v_s1 * v_s1;

	assign offs = (TW+1)'($signed({1'b0, cfg.off}));
	assign nx   = (TW+1)'(x2_s2) - offs;
	assign ny   = (TW+1)'(y2_s2) - offs;
	assign ax   = nx[TW] ? -nx : nx;
	assign ay   = ny[TW] ? -ny : ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd;
		sidx_s1 <= load_index;
		x_s1    <= seed_x;
		y_s1    <= seed_y;
		u_s1    <= flow_u;
		v_s1    <= flow_v;

		cmd_s2  <= cmd_s1;
		sidx_s2 <= sidx_s1;
		u_s2    <= u_s1;
		v_s2    <= v_s1;
		fsq_s2  <= ffbc_pkg::SQ_W'($unsigned(usq)) + ffbc_pkg::SQ_W'($unsigned(vsq));
		x2_s2   <= round_tgt(x_s1, u_s1);
		y2_s2   <= round_tgt(y_s1, v_s1);

		item_s3.cmd        <= cmd_s2;
		item_s3.load_index <= sidx_s2;
		item_s3.u          <= u_s2;
		item_s3.v          <= v_s2;
		item_s3.fwd_bad    <= fsq_s2 > cfg.md2;
		item_s3.negx       <= nx[TW];
		item_s3.negy       <= ny[TW];
		magx_s3            <= ax[DW-1:0];
		magy_s3            <= ay[DW-1:0];
	end

	ffbc_div u_div_x (.clk(clk), .num(magx_s3), .den(cfg.grid), .quo(qx));
	ffbc_div u_div_y (.clk(clk), .num(magy_s3), .den(cfg.grid), .quo(qy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DW; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else begin
			valid_d[0] <= valid_s3;
			for (int k = 1; k < DW; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		item_d[0] <= item_s3;
		for (int k = 1; k < DW; k++) begin
			item_d[k] <= item_d[k-1];
		end
	end

	always_comb begin
		push_item.cmd        = item_d[DW-1].cmd;
		push_item.load_index = item_d[DW-1].load_index;
		push_item.u          = item_d[DW-1].u;
		push_item.v          = item_d[DW-1].v;
		push_item.fwd_bad    = item_d[DW-1].fwd_bad;
		push_item.sx         = item_d[DW-1].negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		push_item.sy         = item_d[DW-1].negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
	end

	assign push = valid_d[DW-1];

endmodule

[rtl/ffbc_queue.sv]
// Short FIFO between the front end and the back end.
// Depends on ffbc_pkg for the entry type.
module ffbc_queue #(
	parameter int DEPTH = ffbc_pkg::Q_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ffbc_pkg::q_item_t push_item,
	input  logic              pop,
	output ffbc_pkg::q_item_t pop_item,
	output logic              empty,
	output logic              full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ffbc_pkg::q_item_t entry_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign empty    = count_q == '0;
	assign full     = count_q == CW'(DEPTH);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue overflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop");
`endif

endmodule

[rtl/ffbc_back.sv]
// Back end: grid and border tests, backward flow table, consistency checks.
// Depends on ffbc_pkg.
module ffbc_back #(
	parameter int MAX_SEEDS = ffbc_pkg::MAX_SEEDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ffbc_pkg::cfg_t                     cfg,
	input  logic                               empty,
	input  ffbc_pkg::q_item_t                  pop_item,
	output logic                               pop,
	output logic                               done,
	output logic                               match_valid,
	output logic signed [ffbc_pkg::FLOW_W-1:0] out_u,
	output logic signed [ffbc_pkg::FLOW_W-1:0] out_v,
	output logic [ffbc_pkg::CAUSE_W-1:0]       reject_cause
);

	localparam int AW  = $clog2(MAX_SEEDS);
	localparam int TW  = ffbc_pkg::TGT_W;
	localparam int FW  = ffbc_pkg::FLOW_W;
	localparam int IXW = 2 * TW + 1;
	localparam int OXW = TW + ffbc_pkg::GRID_W + 2;
	localparam int SIW = 18;

	ffbc_pkg::q_item_t it_s1;
	logic              valid_s1;

	logic              valid_s2, cmd_s2, fwd_bad_s2, range_bad_s2;
	logic [ffbc_pkg::SEED_IDX_W-1:0] sidx_s2;
	logic signed [FW-1:0] u_s2, v_s2;
	logic signed [IXW-1:0] idx_s2;
	logic signed [OXW-1:0] ox_s2, oy_s2;

	logic              valid_s3, cmd_s3;
	logic [ffbc_pkg::CAUSE_W-1:0] cause_s3;
	logic signed [FW-1:0] u_s3, v_s3;
	logic [2*FW-1:0]   rd_q;

	logic              valid_s4, cmd_s4;
	logic [ffbc_pkg::CAUSE_W-1:0] cause_s4;
	logic signed [FW-1:0] u_s4, v_s4;
	logic [ffbc_pkg::SQ_W-1:0] bsq_s4;
	logic signed [FW:0] su_s4, sv_s4;

	logic              valid_s5, cmd_s5, bwd_bad_s5;
	logic [ffbc_pkg::CAUSE_W-1:0] cause_s5;
	logic signed [FW-1:0] u_s5, v_s5;
	logic [ffbc_pkg::SQ_W+1:0] ssq_s5;

	logic [2*FW-1:0]   mem_q [MAX_SEEDS];

	logic signed [2*TW-1:0]   prod_i;
	logic signed [TW-1:0]     spr_s, spc_s;
	logic signed [OXW-1:0]    g_s, off_s, bw_s, wlim, hlim;
	logic                     idx_bad, border_bad, grid_bad, load_ok;
	logic [SIW-1:0]           sidx_ext;
	logic signed [FW-1:0]     u2, v2;
	logic signed [2*FW-1:0]   u2sq, v2sq;
	logic signed [2*FW+1:0]   susq, svsq;
	logic [ffbc_pkg::CAUSE_W-1:0] cause_f;

	assign pop   = !empty;
	assign spr_s = TW'($signed({1'b0, cfg.spr}));
	assign spc_s = TW'($signed({1'b0, cfg.spc}));
	assign g_s   = OXW'($signed({1'b0, cfg.grid}));
	assign off_s = OXW'($signed({1'b0, cfg.off}));
	assign bw_s  = OXW'($signed({1'b0, cfg.bw}));
	assign wlim  = OXW'($signed({1'b0, cfg.iw})) - bw_s;
	assign hlim  = OXW'($signed({1'b0, cfg.ih})) - bw_s;

	assign prod_i = (2*TW)'(it_s1.sy) * (2*TW)'(spr_s);

	assign idx_bad    = idx_s2 >= IXW'(MAX_SEEDS);
	assign border_bad = ox_s2 < bw_s || ox_s2 >= wlim || oy_s2 < bw_s || oy_s2 >= hlim;
	assign grid_bad   = range_bad_s2 || idx_bad || border_bad;
	assign sidx_ext   = SIW'(sidx_s2);
	assign load_ok    = sidx_ext < SIW'(MAX_SEEDS);

	assign u2   = $signed(rd_q[FW-1:0]);
	assign v2   = $signed(rd_q[2*FW-1:FW]);
	assign u2sq = u2 * u2;
	assign v2sq = v2 * v2;
	assign susq = su_s4 * su_s4;
	assign svsq = sv_s4 * sv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done     <= valid_s5 && cmd_s5 == ffbc_pkg::CMD_CHECK;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= pop_item;

		cmd_s2       <= it_s1.cmd;
		sidx_s2      <= it_s1.load_index;
		u_s2         <= it_s1.u;
		v_s2         <= it_s1.v;
		fwd_bad_s2   <= it_s1.fwd_bad;
		range_bad_s2 <= it_s1.sx < 0 || it_s1.sy < 0 || it_s1.sx >= spr_s || it_s1.sy >= spc_s;
		idx_s2       <= IXW'(prod_i) + IXW'(it_s1.sx);
		ox_s2        <= OXW'(it_s1.sx) * g_s + off_s;
		oy_s2        <= OXW'(it_s1.sy) * g_s + off_s;

		cmd_s3 <= cmd_s2;
		u_s3   <= u_s2;
		v_s3   <= v_s2;
		if (fwd_bad_s2) begin
			cause_s3 <= ffbc_pkg::CAUSE_FWD_BIG;
		end else if (grid_bad) begin
			cause_s3 <= ffbc_pkg::CAUSE_OFF_GRID;
		end else begin
			cause_s3 <= ffbc_pkg::CAUSE_NONE;
		end

		cmd_s4   <= cmd_s3;
		cause_s4 <= cause_s3;
		u_s4     <= u_s3;
		v_s4     <= v_s3;
		bsq_s4   <= ffbc_pkg::SQ_W'($unsigned(u2sq)) + ffbc_pkg::SQ_W'($unsigned(v2sq));
		su_s4    <= (FW+1)'(u_s3) + (FW+1)'(u2);
		sv_s4    <= (FW+1)'(v_s3) + (FW+1)'(v2);

		cmd_s5     <= cmd_s4;
		cause_s5   <= cause_s4;
		u_s5       <= u_s4;
		v_s5       <= v_s4;
		bwd_bad_s5 <= bsq_s4 > cfg.md2;
		ssq_s5     <= (ffbc_pkg::SQ_W+2)'($unsigned(susq)) + (ffbc_pkg::SQ_W+2)'($unsigned(svsq));

		match_valid  <= cause_f == ffbc_pkg::CAUSE_NONE;
		reject_cause <= cause_f;
		out_u        <= (cause_f == ffbc_pkg::CAUSE_NONE) ? u_s5 : '0;
		out_v        <= (cause_f == ffbc_pkg::CAUSE_NONE) ? v_s5 : '0;
	end

	always_comb begin
		if (cause_s5 != ffbc_pkg::CAUSE_NONE) begin
			cause_f = cause_s5;
		end else if (bwd_bad_s5) begin
			cause_f = ffbc_pkg::CAUSE_BWD_BIG;
		end else if (ssq_s5 > {2'b00, cfg.th2}) begin
			cause_f = ffbc_pkg::CAUSE_MISMATCH;
		end else begin
			cause_f = ffbc_pkg::CAUSE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && cmd_s2 == ffbc_pkg::CMD_LOAD && load_ok) begin
			mem_q[sidx_ext[AW-1:0]] <= {v_s2, u_s2};
		end
		rd_q <= mem_q[idx_s2[AW-1:0]];
	end

endmodule

[rtl/flow_forward_backward_check_unit.sv]
// A check beat passes the front end, queue and back end to a result; loads give none.
// One beat per cycle unless busy, set by the pipelined seed divider and the table read port.
// arst_n clears control, presets configuration; the backward flow table is not cleared.
// The receiver cannot stall: done is high for one cycle per result.
// Top level: configuration registers, front end, queue and back end.
// Depends on ffbc_pkg, ffbc_front, ffbc_queue and ffbc_back.
module flow_forward_backward_check_unit #(
	parameter int MAX_SEEDS = ffbc_pkg::MAX_SEEDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cmd,
	input  logic [ffbc_pkg::SEED_IDX_W-1:0]       load_index,
	input  logic [ffbc_pkg::POS_W-1:0]            seed_x,
	input  logic [ffbc_pkg::POS_W-1:0]            seed_y,
	input  logic signed [ffbc_pkg::FLOW_W-1:0]    flow_u,
	input  logic signed [ffbc_pkg::FLOW_W-1:0]    flow_v,
	input  logic                                  cfg_we,
	input  logic [ffbc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ffbc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic                                  done,
	output logic                                  match_valid,
	output logic signed [ffbc_pkg::FLOW_W-1:0]    out_u,
	output logic signed [ffbc_pkg::FLOW_W-1:0]    out_v,
	output logic [ffbc_pkg::CAUSE_W-1:0]          reject_cause
);

	logic [ffbc_pkg::GRID_W-1:0] grid_q, border_q;
	logic [ffbc_pkg::DIM_W-1:0]  spr_q, spc_q, iw_q, ih_q;
	logic [15:0]                 maxdisp_q, thresh_q;
	logic [ffbc_pkg::SQ_W-1:0]   md2_q, th2_q;
	logic [ffbc_pkg::GRID_W-1:0] grid_eff;
	ffbc_pkg::cfg_t              cfg;

	logic              push, pop, empty, full;
	ffbc_pkg::q_item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q    <= 8'd4;
			spr_q     <= 13'd64;
			spc_q     <= 13'd64;
			iw_q      <= 13'd256;
			ih_q      <= 13'd256;
			border_q  <= 8'd5;
			maxdisp_q <= 16'hFFFF;
			thresh_q  <= 16'd48;
		end else if (cfg_we) begin
			case (cfg_index)
				ffbc_pkg::REG_GRID:    grid_q    <= cfg_wdata[ffbc_pkg::GRID_W-1:0];
				ffbc_pkg::REG_SPR:     spr_q     <= cfg_wdata[ffbc_pkg::DIM_W-1:0];
				ffbc_pkg::REG_SPC:     spc_q     <= cfg_wdata[ffbc_pkg::DIM_W-1:0];
				ffbc_pkg::REG_WIDTH:   iw_q      <= cfg_wdata[ffbc_pkg::DIM_W-1:0];
				ffbc_pkg::REG_HEIGHT:  ih_q      <= cfg_wdata[ffbc_pkg::DIM_W-1:0];
				ffbc_pkg::REG_BORDER:  border_q  <= cfg_wdata[ffbc_pkg::GRID_W-1:0];
				ffbc_pkg::REG_MAXDISP: maxdisp_q <= cfg_wdata;
				ffbc_pkg::REG_THRESH:  thresh_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		md2_q <= ffbc_pkg::SQ_W'(maxdisp_q) * ffbc_pkg::SQ_W'(maxdisp_q);
		th2_q <= ffbc_pkg::SQ_W'(thresh_q) * ffbc_pkg::SQ_W'(thresh_q);
	end

	assign grid_eff = (grid_q == '0) ? 8'd1 : grid_q;

	always_comb begin
		cfg.grid = grid_eff;
		cfg.off  = grid_eff[ffbc_pkg::GRID_W-1:1];
		cfg.spr  = spr_q;
		cfg.spc  = spc_q;
		cfg.iw   = iw_q;
		cfg.ih   = ih_q;
		cfg.bw   = border_q;
		cfg.md2  = md2_q;
		cfg.th2  = th2_q;
	end

	assign busy = full;

	ffbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (start && !busy),
		.cmd        (cmd),
		.load_index (load_index),
		.seed_x     (seed_x),
		.seed_y     (seed_y),
		.flow_u     (flow_u),
		.flow_v     (flow_v),
		.push       (push),
		.push_item  (push_item)
	);

	ffbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty),
		.full      (full)
	);

	ffbc_back #(.MAX_SEEDS(MAX_SEEDS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.empty        (empty),
		.pop_item     (pop_item),
		.pop          (pop),
		.done         (done),
		.match_valid  (match_valid),
		.out_u        (out_u),
		.out_v        (out_v),
		.reject_cause (reject_cause)
	);

endmodule

[tb/sv/ffbc_checker.sv]
// Checker for the flow forward/backward check unit: watches the command, configuration
// and result ports, predicts each check verdict and compares it with the observed one.
// Depends on ffbc_pkg.
module ffbc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            cmd,
	input  logic [ffbc_pkg::SEED_IDX_W-1:0] load_index,
	input  logic [ffbc_pkg::POS_W-1:0]      seed_x,
	input  logic [ffbc_pkg::POS_W-1:0]      seed_y,
	input  logic [ffbc_pkg::FLOW_W-1:0]     flow_u,
	input  logic [ffbc_pkg::FLOW_W-1:0]     flow_v,
	input  logic                            cfg_we,
	input  logic [ffbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            done,
	input  logic                            match_valid,
	input  logic [ffbc_pkg::FLOW_W-1:0]     out_u,
	input  logic [ffbc_pkg::FLOW_W-1:0]     out_v,
	input  logic [ffbc_pkg::CAUSE_W-1:0]    reject_cause,
	output int                              errors,
	output int                              pending
);
	import ffbc_pkg::*;

	typedef struct {
		logic              mv;
		logic [15:0]       u;
		logic [15:0]       v;
		logic [CAUSE_W-1:0] cause;
	} verdict_t;

	logic [7:0]  grid, border;
	logic [12:0] spr, spc, img_w, img_h;
	logic [15:0] max_disp, thresh;
	logic [31:0] bwd_flow [MAX_SEEDS_DEF];
	verdict_t    verdicts [$];
	int          results_seen;

	function automatic longint sq(input longint a, input longint b);
		return a * a + b * b;
	endfunction

	function automatic longint round_pos(input logic [11:0] p, input logic [15:0] f);
		longint t, q;
		t = longint'(p) * 16 + longint'($signed(f)) + 65536;
		q = (t >>> 4) - 4096;
		if ((t & 15) > 8 || ((t & 15) == 8 && (q & 1) == 1))
			q++;
		return q;
	endfunction

	function automatic void judge(input logic [11:0] x, input logic [11:0] y,
			input logic [15:0] u, input logic [15:0] v,
			output logic [CAUSE_W-1:0] cause, output int rd);
		longint g, off, sx, sy, idx, ox, oy, bw, md2, th2, u1, v1, u2, v2;
		rd = -1;
		cause = CAUSE_NONE;
		u1 = longint'($signed(u));
		v1 = longint'($signed(v));
		g = (grid == 0) ? 1 : longint'(grid);
		off = g / 2;
		bw = longint'(border);
		md2 = longint'(max_disp) * longint'(max_disp);
		th2 = longint'(thresh) * longint'(thresh);
		if (sq(u1, v1) > md2) begin
			cause = CAUSE_FWD_BIG;
		end else begin
			sx = (round_pos(x, u) - off) / g;
			sy = (round_pos(y, v) - off) / g;
			idx = sy * longint'(spr) + sx;
			ox = sx * g + off;
			oy = sy * g + off;
			if (sx < 0 || sy < 0 || sx >= longint'(spr) || sy >= longint'(spc) ||
					idx >= MAX_SEEDS_DEF || ox < bw || ox >= longint'(img_w) - bw ||
					oy < bw || oy >= longint'(img_h) - bw) begin
				cause = CAUSE_OFF_GRID;
			end else begin
				rd = int'(idx);
				u2 = longint'($signed(bwd_flow[idx][15:0]));
				v2 = longint'($signed(bwd_flow[idx][31:16]));
				if (sq(u2, v2) > md2)
					cause = CAUSE_BWD_BIG;
				else if (sq(u1 + u2, v1 + v2) > th2)
					cause = CAUSE_MISMATCH;
			end
		end
	endfunction

	function automatic int table_index(input logic [11:0] x, input logic [11:0] y,
			input logic [15:0] u, input logic [15:0] v);
		logic [CAUSE_W-1:0] c;
		int rd;
		judge(x, y, u, v, c, rd);
		return rd;
	endfunction

	task automatic report(input string field, input int got, input int want);
		$display("result %0d: %s got %0h expected %0h", results_seen, field, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		foreach (bwd_flow[i])
			bwd_flow[i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		verdict_t w, e;
		int rd;
		if (!arst_n) begin
			grid = 8'd4;
			spr = 13'd64;
			spc = 13'd64;
			img_w = 13'd256;
			img_h = 13'd256;
			border = 8'd5;
			max_disp = 16'hffff;
			thresh = 16'd48;
			verdicts.delete();
		end else begin
			if (done) begin
				if (verdicts.size() == 0) begin
					$display("result %0d: no verdict pending", results_seen);
					errors++;
				end else begin
					e = verdicts.pop_front();
					if (match_valid !== e.mv) report("match_valid", match_valid, e.mv);
					if (out_u !== e.u) report("out_u", out_u, e.u);
					if (out_v !== e.v) report("out_v", out_v, e.v);
					if (reject_cause !== e.cause) report("reject_cause", reject_cause, e.cause);
				end
				results_seen++;
			end
			if (start && !busy) begin
				if (cmd == CMD_LOAD) begin
					bwd_flow[load_index] = {flow_v, flow_u};
				end else begin
					judge(seed_x, seed_y, flow_u, flow_v, w.cause, rd);
					w.mv = (w.cause == CAUSE_NONE);
					w.u = w.mv ? flow_u : 16'd0;
					w.v = w.mv ? flow_v : 16'd0;
					verdicts.push_back(w);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID:    grid = cfg_wdata[7:0];
					REG_SPR:     spr = cfg_wdata[12:0];
					REG_SPC:     spc = cfg_wdata[12:0];
					REG_WIDTH:   img_w = cfg_wdata[12:0];
					REG_HEIGHT:  img_h = cfg_wdata[12:0];
					REG_BORDER:  border = cfg_wdata[7:0];
					REG_MAXDISP: max_disp = cfg_wdata;
					REG_THRESH:  thresh = cfg_wdata;
					default: ;
				endcase
			end
		end
		pending = verdicts.size();
	end

endmodule

[tb/sv/tb_flow_forward_backward_check_unit.sv]
// Testbench top for the flow forward/backward check unit: clock, reset, load and check
// beats under several grid settings, and the verdict.
// Depends on ffbc_pkg, ffbc_checker and flow_forward_backward_check_unit.
module tb_flow_forward_backward_check_unit;
	import ffbc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cmd = 1'b0;
	logic [11:0] load_index = '0;
	logic [11:0] seed_x = '0;
	logic [11:0] seed_y = '0;
	logic [15:0] flow_u = '0;
	logic [15:0] flow_v = '0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        done, match_valid;
	logic [15:0] out_u, out_v;
	logic [2:0]  reject_cause;
	int          errors, pending;
	int          cycles = 0;
	int          send_idle = 0;
	int          sent = 0;
	bit          loaded [MAX_SEEDS_DEF];
	logic [7:0]  grid_now = 8'd4;

	always #2 clk = ~clk;

	flow_forward_backward_check_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.load_index(load_index), .seed_x(seed_x), .seed_y(seed_y),
		.flow_u(flow_u), .flow_v(flow_v), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .match_valid(match_valid),
		.out_u(out_u), .out_v(out_v), .reject_cause(reject_cause)
	);

	ffbc_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.load_index(load_index), .seed_x(seed_x), .seed_y(seed_y),
		.flow_u(flow_u), .flow_v(flow_v), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .match_valid(match_valid),
		.out_u(out_u), .out_v(out_v), .reject_cause(reject_cause),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic beat(input logic c, input logic [11:0] i, input logic [11:0] x,
			input logic [11:0] y, input logic [15:0] u, input logic [15:0] v);
		logic acc;
		if ($urandom_range(0, 99) < send_idle) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		load_index <= i;
		seed_x <= x;
		seed_y <= y;
		flow_u <= u;
		flow_v <= v;
		do begin
			@(negedge clk);
			acc = !busy;
			@(posedge clk);
		end while (!acc);
		sent++;
		if (c == CMD_LOAD)
			loaded[i] = 1'b1;
	endtask

	// load the target entry first when the check would read an unwritten one
	task automatic check(input logic [11:0] x, input logic [11:0] y,
			input logic [15:0] u, input logic [15:0] v);
		int rd;
		rd = chk.table_index(x, y, u, v);
		if (rd >= 0 && !loaded[rd]) begin
			if ($urandom_range(0, 1))
				beat(CMD_LOAD, 12'(rd), 12'($urandom), 12'($urandom), 16'(-$signed(u) +
					$urandom_range(0, 128) - 64), 16'(-$signed(v) +
					$urandom_range(0, 128) - 64));
			else
				beat(CMD_LOAD, 12'(rd), 12'($urandom), 12'($urandom), 16'($urandom),
					16'($urandom));
		end
		beat(CMD_CHECK, 12'($urandom), x, y, u, v);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic setup(input int k);
		logic [15:0] r [8];
		case (k % 4)
			0: r = '{16'd1, 16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd0,
				16'hffff, 16'hffff};
			1: r = '{16'd255, 16'd16, 16'd16, 16'd4095, 16'd4095, 16'd255,
				16'd3000, 16'd64};
			2: r = '{16'd0, 16'd8191, 16'd1, 16'd10, 16'd4096, 16'd5,
				16'd0, 16'd0};
			default: r = '{16'($urandom_range(1, 24)), 16'($urandom_range(1, 8191)),
				16'($urandom_range(1, 8191)), 16'($urandom_range(1, 8191)),
				16'($urandom_range(1, 8191)), 16'($urandom_range(0, 40)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 300))};
		endcase
		drain();
		for (int i = 0; i < 8; i++)
			write_reg(i[2:0], r[i]);
		cfg_we <= 1'b0;
		grid_now = r[0][7:0];
		@(posedge clk);
	endtask

	task automatic random_beat();
		int g, tx, ty, x, y, sel;
		sel = $urandom_range(0, 99);
		g = (grid_now == 0) ? 1 : int'(grid_now);
		if (sel < 20) begin
			beat(CMD_LOAD, 12'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
				16'($urandom));
		end else if (sel < 40) begin
			check(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			tx = ($urandom_range(0, 4095) / g) * g + g / 2;
			ty = ($urandom_range(0, 4095) / g) * g + g / 2;
			x = tx + $urandom_range(0, 600) - 300;
			y = ty + $urandom_range(0, 600) - 300;
			x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
			y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
			check(12'(x), 12'(y), 16'((tx - x) * 16 + $urandom_range(0, 16) - 8),
				16'((ty - y) * 16 + $urandom_range(0, 16) - 8));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		beat(CMD_LOAD, 12'd0, 12'd0, 12'd0, 16'h0000, 16'h0000);
		beat(CMD_LOAD, 12'd4095, 12'hfff, 12'hfff, 16'h7fff, 16'h8000);
		beat(CMD_LOAD, 12'd130, 12'd0, 12'd0, 16'h7fff, 16'h8000);
		check(12'd10, 12'd10, 16'h0000, 16'h0000);
		check(12'd10, 12'd10, 16'h8000, 16'h8000);
		check(12'd4095, 12'd4095, 16'h7fff, 16'h7fff);
		check(12'd0, 12'd0, 16'h0000, 16'h0000);
		check(12'd10, 12'd10, 16'h0008, 16'h0018);
		check(12'd10, 12'd10, 16'h0018, 16'hfff8);
		check(12'd9, 12'd11, 16'hfff8, 16'h0028);
		beat(CMD_LOAD, 12'd200, 12'd0, 12'd0, 16'hfff0, 16'h0010);
		check(12'd33, 12'd10, 16'h0010, 16'hfff0);
		check(12'd250, 12'd250, 16'h0000, 16'h0000);
		drain();
		write_reg(REG_MAXDISP, 16'd100);
		cfg_we <= 1'b0;
		@(posedge clk);
		beat(CMD_LOAD, 12'd130, 12'd0, 12'd0, 16'd2000, 16'd0);
		check(12'd10, 12'd10, 16'h0000, 16'h0000);
		check(12'd10, 12'd10, 16'd2000, 16'h0000);
		beat(CMD_LOAD, 12'd130, 12'd0, 12'd0, 16'hffc0, 16'h0000);
		check(12'd10, 12'd10, 16'h0040, 16'h0000);
		check(12'd10, 12'd10, 16'h0040, 16'h0010);

		for (int k = 0; k < 9; k++) begin
			send_idle = (k < 3) ? 6 : ((k < 6) ? 46 : 0);
			setup(k);
			while (sent < 20 + (k + 1) * 70)
				random_beat();
		end
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
